@@ rtl/ik_pkg.sv @@
// ----------------------------------------------------------------------------
// ik_pkg
// Shared types, widths, angle constants and the CORDIC arctangent table
// for the two-link inverse kinematics block.
// ----------------------------------------------------------------------------
package ik_pkg;

  // Link length register width and register indexes
  localparam int LINK_W   = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LINK = 1'd1;
  localparam logic [LINK_W-1:0] LINK_RESET = 13'd3456;

  // Serial multiplier widths
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;

  // Square root widths (radicand below 2^54)
  localparam int SQ_IN_W   = 54;
  localparam int SQ_ROOT_W = 27;
  localparam int SQ_REM_W  = 30;

  // CORDIC widths
  localparam int COR_IN_W   = 42;
  localparam int COR_W      = 44;
  localparam int COR_NORM_B = 40;
  localparam int COR_Z_W    = 24;
  localparam int COR_OUT_W  = 16;

  // Intermediate widths
  localparam int LSQ_W  = 26;
  localparam int K_W    = 27;
  localparam int M_W    = 27;
  localparam int D_W    = 27;
  localparam int BS_W   = 40;
  localparam int ANG_W  = 17;
  localparam int PULSE_W = 12;

  // Angles in Q.7 degrees
  localparam logic signed [ANG_W-1:0] DEG90_Q7  = 17'sd11520;
  localparam logic signed [ANG_W-1:0] DEG180_Q7 = 17'sd23040;
  localparam logic signed [ANG_W-1:0] DEG100_Q7 = 17'sd12800;
  localparam logic signed [ANG_W-1:0] DEG10_Q7  = 17'sd1280;
  localparam logic [PULSE_W-1:0] PULSE_BASE_US = 12'd600;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_REJECT   = 2'd1;
  localparam logic [1:0] STAT_TRIANGLE = 2'd2;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_MUL_XX, S_MUL_YY, S_MUL_L1, S_MUL_L2, S_MUL_M, S_REACH,
    S_MUL_MM, S_MUL_DD, S_MUL_RH, S_SQRT, S_COR_S2, S_MUL_C1, S_MUL_C2,
    S_MUL_LS, S_COR_AS, S_COR_AT, S_FINAL, S_DONE
  } ik_state_e;

  // CORDIC phases
  typedef enum logic [1:0] {
    COR_IDLE, COR_NORM, COR_ROT
  } cor_state_e;

  // atan(2^-i) in Q.16 degrees
  function automatic logic [21:0] atan_step(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // Clamp a Q.7 angle to 0..180 degrees and map it to a servo pulse
  function automatic logic [PULSE_W-1:0] pulse_us(input logic signed [ANG_W-1:0] a);
    logic [14:0] ac;
    logic [17:0] t;
    if (a < 0) ac = 15'd0;
    else if (a > DEG180_Q7) ac = 15'(DEG180_Q7);
    else ac = a[14:0];
    t = 18'(ac) * 18'd10 + 18'd64;
    return PULSE_BASE_US + PULSE_W'(t >> 7);
  endfunction

endpackage

@@ rtl/ik_mul.sv @@
// ----------------------------------------------------------------------------
// ik_mul
// Bit-serial shift-and-add multiplier with accumulate: prod = init + a * b,
// one multiplier bit per cycle, stops early once the remaining bits are zero.
// ----------------------------------------------------------------------------
module ik_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ik_pkg::MUL_A_W-1:0]   a_i,
  input  logic [ik_pkg::MUL_B_W-1:0]   b_i,
  input  logic [ik_pkg::MUL_A_W-1:0]   init_i,
  output logic                         busy_o,
  output logic [ik_pkg::MUL_A_W-1:0]   prod_o
);
  import ik_pkg::*;

  logic               busy_q;
  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_A_W-1:0] acc_q;

  // Control: run until the multiplier register drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && b_q == '0) begin
      busy_q <= 1'b0;
    end
  end

  // Datapath: add shifted multiplicand for each set bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= init_i;
    end else if (busy_q && b_q != '0) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= {a_q[MUL_A_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[MUL_B_W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

@@ rtl/ik_sqrt.sv @@
// ----------------------------------------------------------------------------
// ik_sqrt
// Digit-serial integer square root: two radicand bits enter per cycle,
// one root bit leaves per cycle (restoring method).
// ----------------------------------------------------------------------------
module ik_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ik_pkg::SQ_IN_W-1:0]    rad_i,
  output logic                          busy_o,
  output logic [ik_pkg::SQ_ROOT_W-1:0]  root_o
);
  import ik_pkg::*;

  localparam int CNT_W = $clog2(SQ_ROOT_W);

  logic                 busy_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SQ_IN_W-1:0]   rad_q;
  logic [SQ_REM_W-1:0]  rem_q;
  logic [SQ_ROOT_W-1:0] root_q;
  logic [SQ_REM_W-1:0]  rem_n;
  logic [SQ_REM_W-1:0]  trial;

  // Bring down the next bit pair and form the trial subtrahend
  assign rem_n = {rem_q[SQ_REM_W-3:0], rad_q[SQ_IN_W-1:SQ_IN_W-2]};
  assign trial = SQ_REM_W'({root_q, 2'b01});

  // Control: one step per root bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(SQ_ROOT_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Datapath: keep remainder and partial root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[SQ_IN_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

@@ rtl/ik_cordic.sv @@
// ----------------------------------------------------------------------------
// ik_cordic
// Vectoring CORDIC for atan2(b, a) with a, b >= 0. Operands are doubled one
// bit per cycle until one reaches 2^40, then one rotation per cycle.
// ----------------------------------------------------------------------------
module ik_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [ik_pkg::COR_IN_W-1:0]          a_i,
  input  logic [ik_pkg::COR_IN_W-1:0]          b_i,
  output logic                                 busy_o,
  output logic signed [ik_pkg::COR_OUT_W-1:0]  angle_o
);
  import ik_pkg::*;

  localparam int IT_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  cor_state_e                 state_q, state_d;
  logic [IT_W-1:0]            it_q;
  logic signed [COR_W-1:0]    xc_q, yc_q;
  logic signed [COR_Z_W-1:0]  zc_q;
  logic [4:0]                 k;
  logic signed [COR_W-1:0]    dx, dy;
  logic signed [COR_Z_W-1:0]  step;
  logic                       both_zero, normalized, last_it;
  logic signed [COR_Z_W-1:0]  z_round;

  // Shift amount saturates at 31, the largest 5-bit table index
  assign k         = (32'(it_q) > 32'd31) ? 5'd31 : 5'(it_q);
  assign dx        = yc_q >>> k;
  assign dy        = xc_q >>> k;
  assign step      = COR_Z_W'(atan_step(k));
  assign both_zero = (xc_q == '0) && (yc_q == '0);
  assign normalized = (xc_q[COR_W-1:COR_NORM_B] != '0) || (yc_q[COR_W-1:COR_NORM_B] != '0);
  assign last_it   = (it_q == IT_W'(ITERATIONS - 1));

  // Next phase
  always_comb begin
    state_d = state_q;
    case (state_q)
      COR_IDLE: begin
        if (start_i) state_d = COR_NORM;
      end
      COR_NORM: begin
        if (both_zero) state_d = COR_IDLE;
        else if (normalized) state_d = COR_ROT;
      end
      COR_ROT: begin
        if (last_it) state_d = COR_IDLE;
      end
      default: state_d = COR_IDLE;
    endcase
  end

  // Phase outputs
  always_comb begin
    case (state_q)
      COR_IDLE: busy_o = 1'b0;
      default:  busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COR_IDLE;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == COR_ROT) it_q <= it_q + 1'b1;
      else it_q <= '0;
    end
  end

  // Datapath: normalize, then rotate toward the x axis
  always_ff @(posedge clk_i) begin
    case (state_q)
      COR_IDLE: begin
        if (start_i) begin
          xc_q <= COR_W'(a_i);
          yc_q <= COR_W'(b_i);
          zc_q <= '0;
        end
      end
      COR_NORM: begin
        if (!both_zero && !normalized) begin
          xc_q <= xc_q <<< 1;
          yc_q <= yc_q <<< 1;
        end
      end
      COR_ROT: begin
        if (yc_q >= 0) begin
          xc_q <= xc_q + dx;
          yc_q <= yc_q - dy;
          zc_q <= zc_q + step;
        end else begin
          xc_q <= xc_q - dx;
          yc_q <= yc_q + dy;
          zc_q <= zc_q - step;
        end
      end
      default: ;
    endcase
  end

  // Round Q.16 to Q.7, half up
  assign z_round = zc_q + COR_Z_W'(256);
  assign angle_o = COR_OUT_W'(z_round >>> 9);

endmodule

@@ rtl/two_link_arm_inverse_kinematics.sv @@
// Run time: for a solved target it is set mostly by the bit-serial
//   multiplier (one multiplier bit per cycle, eleven products) and three
//   CORDIC runs of a normalize phase plus CORDIC_ITERATIONS rotations.
//   An origin, zero-link, out-of-reach or triangle-failing target finishes sooner.
// Throughput: one target at a time; the next is taken once the result sits
//   in the output register. Results leave in input order.
// Reset: links return to 13.50 cm, held position to zero, no result pending.
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics
// Sequencer around a shared serial multiplier, a digit-serial square root
// and a vectoring CORDIC; solves shoulder and elbow servo pulses.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics #(
  parameter int COORD_WIDTH       = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ik_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ik_pkg::LINK_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]      target_x_i,
  input  logic signed [COORD_WIDTH-1:0]      target_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [ik_pkg::PULSE_W-1:0]         shoulder_pulse_us_o,
  output logic [ik_pkg::PULSE_W-1:0]         elbow_pulse_us_o,
  output logic signed [COORD_WIDTH-1:0]      held_x_o,
  output logic signed [COORD_WIDTH-1:0]      held_y_o
);
  import ik_pkg::*;

  localparam int W = COORD_WIDTH;

  ik_state_e state_q, state_d;
  logic      launched_q;

  // Configuration
  logic [LINK_W-1:0] l1_q, l2_q;

  // Working registers
  logic signed [W-1:0]  x_q, y_q;
  logic [W-1:0]         ux, uy;
  logic [63:0]          r2_q;
  logic [LSQ_W-1:0]     l1sq_q;
  logic [K_W-1:0]       ksum_q;
  logic [M_W-1:0]       m_q;
  logic [D_W-1:0]       dabs_q;
  logic                 dneg_q;
  logic [63:0]          tmp_q;
  logic [SQ_ROOT_W-1:0] s_q;
  logic [BS_W-1:0]      bsin_q;
  logic signed [ANG_W-1:0] s2_q, as_q, at_q;
  logic [1:0]           st_q;
  logic [PULSE_W-1:0]   sp_q, ep_q;

  // Output register
  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [PULSE_W-1:0]   out_sp_q, out_ep_q;
  logic signed [W-1:0]  held_x_q, held_y_q;

  // Unit handshakes
  logic               mul_start, mul_busy, mul_done;
  logic [MUL_A_W-1:0] mul_a, mul_init, mul_prod;
  logic [MUL_B_W-1:0] mul_b;
  logic               sq_start, sq_busy, sq_done;
  logic [SQ_ROOT_W-1:0] sq_root;
  logic               cor_start, cor_busy, cor_done;
  logic [COR_IN_W-1:0] cor_a, cor_b;
  logic signed [COR_OUT_W-1:0] cor_angle;

  // Reach and triangle checks
  logic [63:0] kext, mext, diff_up, diff_dn, rhs, cdiff, csum;
  logic        reach_bad, tri_bad, x_zero, in_origin, out_free;

  // Final angle arithmetic
  logic signed [ANG_W-1:0] s1a, s1b, s2a;
  logic                    quad_bad;

  assign ux = x_q[W-1] ? W'(-x_q) : W'(x_q);
  assign uy = y_q[W-1] ? W'(-y_q) : W'(y_q);
  assign x_zero    = (x_q == '0);
  assign in_origin = (target_x_i == '0) && (target_y_i == '0);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign mul_done = launched_q && !mul_busy;
  assign sq_done  = launched_q && !sq_busy;
  assign cor_done = launched_q && !cor_busy;

  assign kext    = 64'(ksum_q);
  assign mext    = 64'(m_q);
  assign diff_up = r2_q - kext;
  assign diff_dn = kext - r2_q;
  assign reach_bad = (r2_q >= kext) ? (diff_up > mext) : (diff_dn > mext);
  assign rhs     = {mul_prod[61:0], 2'b00};
  assign tri_bad = tmp_q > rhs;
  assign cdiff   = tmp_q - mul_prod;
  assign csum    = tmp_q + mul_prod;

  assign s1a = at_q - as_q + DEG100_Q7;
  assign s1b = (s1a < 0) ? s1a + DEG180_Q7 : s1a;
  assign s2a = s2_q - DEG10_Q7;
  assign quad_bad = ((s1b < DEG90_Q7) && x_q[W-1]) || ((s1b > DEG90_Q7) && y_q[W-1]);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = in_origin ? S_DONE : S_MUL_XX;
      S_MUL_XX: if (mul_done) state_d = S_MUL_YY;
      S_MUL_YY: if (mul_done) state_d = S_MUL_L1;
      S_MUL_L1: if (mul_done) state_d = S_MUL_L2;
      S_MUL_L2: if (mul_done) state_d = S_MUL_M;
      S_MUL_M:  if (mul_done) state_d = (mul_prod == '0) ? S_DONE : S_REACH;
      S_REACH:  state_d = reach_bad ? S_DONE : S_MUL_MM;
      S_MUL_MM: if (mul_done) state_d = S_MUL_DD;
      S_MUL_DD: if (mul_done) state_d = S_MUL_RH;
      S_MUL_RH: if (mul_done) state_d = tri_bad ? S_DONE : S_SQRT;
      S_SQRT:   if (sq_done) state_d = S_COR_S2;
      S_COR_S2: if (cor_done) state_d = S_MUL_C1;
      S_MUL_C1: if (mul_done) state_d = S_MUL_C2;
      S_MUL_C2: if (mul_done) state_d = S_MUL_LS;
      S_MUL_LS: if (mul_done) state_d = S_COR_AS;
      S_COR_AS: if (cor_done) state_d = S_COR_AT;
      S_COR_AT: if (x_zero || cor_done) state_d = S_FINAL;
      S_FINAL:  state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Unit launches and operand selection
  always_comb begin
    mul_start = 1'b0;
    sq_start  = 1'b0;
    cor_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_init  = '0;
    cor_a     = '0;
    cor_b     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: in_stall_o = 1'b0;
      S_MUL_XX: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(ux); mul_b = MUL_B_W'(ux);
      end
      S_MUL_YY: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(uy); mul_b = MUL_B_W'(uy);
        mul_init = r2_q;
      end
      S_MUL_L1: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(l1_q); mul_b = MUL_B_W'(l1_q);
      end
      S_MUL_L2: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(l2_q); mul_b = MUL_B_W'(l2_q);
        mul_init = MUL_A_W'(l1sq_q);
      end
      S_MUL_M: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(l1_q); mul_b = MUL_B_W'(l2_q);
      end
      S_MUL_MM: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(m_q); mul_b = MUL_B_W'(m_q);
      end
      S_MUL_DD: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(dabs_q); mul_b = MUL_B_W'(dabs_q);
      end
      S_MUL_RH: begin
        mul_start = !launched_q; mul_a = r2_q; mul_b = MUL_B_W'(l1sq_q);
      end
      S_SQRT: sq_start = !launched_q;
      S_COR_S2: begin
        cor_start = !launched_q; cor_a = COR_IN_W'(dabs_q); cor_b = COR_IN_W'(s_q);
      end
      S_MUL_C1: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(m_q); mul_b = MUL_B_W'(l1_q);
      end
      S_MUL_C2: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(dabs_q); mul_b = MUL_B_W'(l2_q);
      end
      S_MUL_LS: begin
        mul_start = !launched_q; mul_a = MUL_A_W'(s_q); mul_b = MUL_B_W'(l2_q);
      end
      S_COR_AS: begin
        cor_start = !launched_q; cor_a = tmp_q[COR_IN_W-1:0]; cor_b = COR_IN_W'(bsin_q);
      end
      S_COR_AT: begin
        cor_start = !launched_q && !x_zero; cor_a = COR_IN_W'(ux); cor_b = COR_IN_W'(uy);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      l1_q        <= LINK_RESET;
      l2_q        <= LINK_RESET;
      out_valid_q <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
    end else begin
      state_q    <= state_d;
      launched_q <= (state_d == state_q) ? (launched_q | mul_start | sq_start | cor_start)
                                         : 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_UPPER_LINK: l1_q <= cfg_data_i;
          REG_LOWER_LINK: l2_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Load the next beat when done, drop the beat once taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        if (st_q == STAT_OK) begin
          held_x_q <= x_q;
          held_y_q <= y_q;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q  <= target_x_i;
        y_q  <= target_y_i;
        st_q <= in_origin ? STAT_REJECT : STAT_OK;
      end
      S_MUL_XX, S_MUL_YY: if (mul_done) r2_q <= mul_prod;
      S_MUL_L1: if (mul_done) l1sq_q <= mul_prod[LSQ_W-1:0];
      S_MUL_L2: if (mul_done) ksum_q <= mul_prod[K_W-1:0];
      S_MUL_M: begin
        if (mul_done) begin
          m_q <= {mul_prod[M_W-2:0], 1'b0};
          if (mul_prod == '0) st_q <= STAT_REJECT;
        end
      end
      S_REACH: begin
        if (reach_bad) st_q <= STAT_REJECT;
        dneg_q <= (r2_q < kext);
        dabs_q <= (r2_q >= kext) ? diff_up[D_W-1:0] : diff_dn[D_W-1:0];
      end
      S_MUL_MM: if (mul_done) tmp_q <= mul_prod;
      S_MUL_DD: if (mul_done) tmp_q <= cdiff;
      S_MUL_RH: if (mul_done && tri_bad) st_q <= STAT_TRIANGLE;
      S_SQRT:   if (sq_done) s_q <= sq_root;
      S_COR_S2: begin
        if (cor_done) s2_q <= dneg_q ? DEG180_Q7 - ANG_W'(cor_angle) : ANG_W'(cor_angle);
      end
      S_MUL_C1: if (mul_done) tmp_q <= mul_prod;
      S_MUL_C2: begin
        // Fold the cosine term to its magnitude
        if (mul_done) begin
          if (dneg_q) tmp_q <= cdiff[63] ? 64'(-cdiff) : cdiff;
          else tmp_q <= csum;
        end
      end
      S_MUL_LS: if (mul_done) bsin_q <= mul_prod[BS_W-1:0];
      S_COR_AS: if (cor_done) as_q <= ANG_W'(cor_angle);
      S_COR_AT: begin
        if (x_zero) begin
          at_q <= y_q[W-1] ? -DEG90_Q7 : DEG90_Q7;
        end else if (cor_done) begin
          at_q <= (x_q[W-1] != y_q[W-1]) ? -ANG_W'(cor_angle) : ANG_W'(cor_angle);
        end
      end
      S_FINAL: begin
        if (quad_bad) st_q <= STAT_REJECT;
        sp_q <= pulse_us(s1b);
        ep_q <= pulse_us(s2a);
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q <= st_q;
          out_sp_q     <= (st_q == STAT_OK) ? sp_q : '0;
          out_ep_q     <= (st_q == STAT_OK) ? ep_q : '0;
        end
      end
      default: ;
    endcase
  end

  ik_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .init_i  (mul_init),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  ik_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (tmp_q[SQ_IN_W-1:0]),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  ik_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .a_i     (cor_a),
    .b_i     (cor_b),
    .busy_o  (cor_busy),
    .angle_o (cor_angle)
  );

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign shoulder_pulse_us_o = out_sp_q;
  assign elbow_pulse_us_o    = out_ep_q;
  assign held_x_o            = held_x_q;
  assign held_y_o            = held_y_q;

endmodule
